// ===== rtl/kse_pkg.sv =====
package kse_pkg;

    localparam int ROW_W           = 7;
    localparam int COL_W           = 2;
    localparam int CODE_W          = COL_W + 4;
    localparam int HOLD_W          = 8;
    localparam int MAX_COLUMNS     = 4;
    localparam int DEF_RING_DEPTH  = 4;
    localparam int DEF_NUM_COLUMNS = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 8'd5;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_GET  = 1'b1;

    typedef struct packed {
        logic              get;
        logic [CODE_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              pushed;
        logic              dropped;
    } t_res;

    function automatic logic [2:0] row_msb(input logic [ROW_W-1:0] rise);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < ROW_W; i++) begin
            if (rise[i]) begin
                r = 3'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/kse_front.sv =====
module kse_front #(
    parameter int NUM_COLUMNS = kse_pkg::DEF_NUM_COLUMNS
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_cfg_valid,
    input  logic [kse_pkg::HOLD_W-1:0]                         i_cfg_data,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  logic                                               i_op,
    input  logic [kse_pkg::MAX_COLUMNS-1:0][kse_pkg::ROW_W-1:0] i_rows,
    output logic                                               o_cmd_valid,
    output kse_pkg::t_cmd                                      o_cmd,
    input  logic                                               i_cmd_ready
);

    logic [kse_pkg::HOLD_W-1:0] r_holdoff_polls;
    logic [kse_pkg::HOLD_W-1:0] r_holdoff_count;
    logic [kse_pkg::HOLD_W-1:0] n_holdoff_count;
    logic [kse_pkg::ROW_W-1:0]  r_hist [NUM_COLUMNS];
    logic                       scan;
    logic                       transfer;
    logic [kse_pkg::CODE_W-1:0] scan_code;
    logic [kse_pkg::ROW_W-1:0]  rise;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign transfer    = i_valid && i_cmd_ready;
    assign scan        = (i_op == kse_pkg::OP_POLL) && (r_holdoff_count == '0);

    always_comb begin
        scan_code = '0;
        rise      = '0;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            rise = i_rows[c] & ~r_hist[c];
            if (rise != '0) begin
                scan_code = {kse_pkg::COL_W'(c), 1'b0, kse_pkg::row_msb(rise)};
            end
        end
    end

    always_comb begin
        o_cmd.get       = (i_op == kse_pkg::OP_GET);
        o_cmd.code      = scan ? scan_code : '0;
        n_holdoff_count = r_holdoff_count;
        if (i_op == kse_pkg::OP_POLL) begin
            n_holdoff_count = scan ? r_holdoff_polls : r_holdoff_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_polls <= kse_pkg::HOLDOFF_RESET;
            r_holdoff_count <= '0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_hist[c] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_holdoff_polls <= i_cfg_data;
            end
            if (transfer) begin
                r_holdoff_count <= n_holdoff_count;
                if (scan) begin
                    for (int c = 0; c < NUM_COLUMNS; c++) begin
                        r_hist[c] <= i_rows[c];
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/kse_queue.sv =====
module kse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kse_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output kse_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(kse_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(kse_pkg::QUEUE_DEPTH + 1);

    kse_pkg::t_cmd    r_slot [kse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(kse_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/kse_back.sv =====
module kse_back #(
    parameter int RING_DEPTH = kse_pkg::DEF_RING_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  kse_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output kse_pkg::t_res o_res
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [kse_pkg::CODE_W-1:0] r_ring [RING_DEPTH];
    logic [kse_pkg::CODE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]           r_head;
    logic [PTR_W-1:0]           r_tail;
    logic [PTR_W-1:0]           n_head;
    logic [PTR_W-1:0]           n_tail;
    logic                       r_out_valid;
    kse_pkg::t_res              r_res;
    kse_pkg::t_res              n_res;
    logic                       take;
    logic                       wr_en;
    logic                       empty;
    logic                       full;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd_ready = !r_out_valid || i_ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign empty       = (r_head == r_tail);
    assign full        = (ring_next(r_head) == r_tail);
    assign o_valid     = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_res  = '0;
        wr_en  = 1'b0;
        if (take) begin
            if (i_cmd.get) begin
                if (!empty) begin
                    n_res.key_code = r_rd_data;
                    n_tail         = ring_next(r_tail);
                end
            end else if (i_cmd.code != '0) begin
                if (full) begin
                    n_res.dropped = 1'b1;
                end else begin
                    wr_en        = 1'b1;
                    n_head       = ring_next(r_head);
                    n_res.pushed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_head] <= i_cmd.code;
        end
        if (wr_en && (r_head == n_tail)) begin
            r_rd_data <= i_cmd.code;
        end else begin
            r_rd_data <= r_ring[n_tail];
        end
        if (take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/keypad_scan_edge_fifo.sv =====
// An input transfer reaches result valid through the command queue, then the result register.
// Throughput: one item per cycle while the output is ready; the output register
// and the 2-entry command queue let input and output stall independently.
// Reset (synchronous, active low): hold-off count, column history, ring pointers,
// queue and output valid clear; the hold-off setting returns to 5. No clearing pass.
module keypad_scan_edge_fifo #(
    parameter int RING_DEPTH  = kse_pkg::DEF_RING_DEPTH,
    parameter int NUM_COLUMNS = kse_pkg::DEF_NUM_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kse_pkg::HOLD_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [kse_pkg::ROW_W-1:0]   i_rows_col0,
    input  logic [kse_pkg::ROW_W-1:0]   i_rows_col1,
    input  logic [kse_pkg::ROW_W-1:0]   i_rows_col2,
    input  logic [kse_pkg::ROW_W-1:0]   i_rows_col3,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [kse_pkg::CODE_W-1:0]  o_key_code,
    output logic                        o_pushed,
    output logic                        o_dropped
);

    logic [kse_pkg::MAX_COLUMNS-1:0][kse_pkg::ROW_W-1:0] rows;
    logic          f_valid;
    logic          f_ready;
    kse_pkg::t_cmd f_cmd;
    logic          q_valid;
    logic          q_ready;
    kse_pkg::t_cmd q_cmd;
    kse_pkg::t_res res;

    assign rows        = {i_rows_col3, i_rows_col2, i_rows_col1, i_rows_col0};
    assign o_cfg_ready = 1'b1;
    assign o_key_code  = res.key_code;
    assign o_pushed    = res.pushed;
    assign o_dropped   = res.dropped;

    kse_front #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_rows      (rows),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    kse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    kse_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

`ifndef ASSERT_OFF
    a_push_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pushed && o_dropped))
        else $error("pushed and dropped both set");

    a_get_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_code != '0) |-> (!o_pushed && !o_dropped))
        else $error("key code with poll flags");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_code != '0) |-> (o_key_code[3:0] != 4'd0 && o_key_code[3] == 1'b0))
        else $error("key code row out of range");

    a_queue_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !f_ready |-> q_valid)
        else $error("queue full but not valid");
`endif

endmodule
